### rtl/cct_pkg.sv
`default_nettype none
package cct_pkg;

  localparam int ROWS_DEF       = 32;
  localparam int COLS_DEF       = 32;
  localparam int FIRST_COL_DEF  = 1;
  localparam int COUNT_BITS_DEF = 16;

  localparam int CMD_W  = 2;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 5;
  localparam int AMT_W  = 16;
  localparam int PCT_W  = 7;
  localparam int HITS_W = 16;

  localparam int MAX_ITEMS = 32;
  localparam int PCT_SCALE = 100;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_HIT   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIT_WR,
    ST_Q_RD,
    ST_Q_CHK,
    ST_Q_DIV,
    ST_Q_EMIT,
    ST_Q_END
  } state_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quot;
  } div_stat_t;

endpackage
`default_nettype wire

### rtl/cluster_contingency_table_core.sv
// hit: read entry and row total, then write both back
// query: reads the count of each column in turn; nonzero columns go through the 7-step shared
//   divider, and each result item may wait on rsp_ready
// clear: writes all 2**clog2(ROWS) * 2**clog2(COLS) table entries, one table entry written per cycle
// after reset the same clearing pass runs; req_ready stays low until it ends
`default_nettype none
module cluster_contingency_table_core #(
  parameter int ROWS       = cct_pkg::ROWS_DEF,
  parameter int COLS       = cct_pkg::COLS_DEF,
  parameter int FIRST_COL  = cct_pkg::FIRST_COL_DEF,
  parameter int COUNT_BITS = cct_pkg::COUNT_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_ready,
  input  wire logic [cct_pkg::CMD_W-1:0]    cmd,
  input  wire logic [cct_pkg::ROW_W-1:0]    row,
  input  wire logic [cct_pkg::COL_W-1:0]    col,
  input  wire logic [cct_pkg::AMT_W-1:0]    amount,
  input  wire logic [cct_pkg::PCT_W-1:0]    min_pct,
  input  wire logic                         best_only,
  output logic                              rsp_valid,
  input  wire logic                         rsp_ready,
  output logic                              found,
  output logic [cct_pkg::COL_W-1:0]         match_col,
  output logic [cct_pkg::PCT_W-1:0]         pct,
  output logic [cct_pkg::HITS_W-1:0]        hits,
  output logic                              last
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int TDEP  = 1 << RW;
  localparam int CB    = COUNT_BITS;
  localparam int TW    = COUNT_BITS + CW;
  localparam int MW    = (COUNT_BITS > cct_pkg::AMT_W) ? COUNT_BITS : cct_pkg::AMT_W;
  localparam int NUMW  = COUNT_BITS + cct_pkg::PCT_W;
  localparam int NW    = $clog2(cct_pkg::MAX_ITEMS + 1);
  localparam int PW    = cct_pkg::PCT_W;

  cct_pkg::state_t state, state_next;

  logic [CB-1:0] cnt_mem [DEPTH];
  logic [TW-1:0] tot_mem [TDEP];
  logic [CB-1:0] cnt_rd;
  logic [TW-1:0] tot_rd;

  logic          cnt_we, cnt_re, tot_we, tot_re;
  logic [AW-1:0] cnt_wa, cnt_ra;
  logic [CB-1:0] cnt_wd;
  logic [RW-1:0] tot_wa, tot_ra;
  logic [TW-1:0] tot_wd;

  logic [AW-1:0] clr_addr;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [cct_pkg::AMT_W-1:0] amount_q;
  logic [PW-1:0] min_q;
  logic          best_q;
  logic [CW-1:0] j;

  logic          have;
  logic [NW-1:0] n;
  logic [CW-1:0] pend_col;
  logic [PW-1:0] pend_pct;
  logic [CB-1:0] pend_hits;

  logic          accept, row_ok, col_ok, last_col, out_free, list_full;
  logic          cnt_zero, pass, take;
  logic [MW-1:0] room_ext, amt_ext;
  logic [CB-1:0] add_amt;
  logic [PW-1:0] pct_val;
  logic          div_start;
  cct_pkg::div_stat_t div_stat;

  assign req_ready = (state == cct_pkg::ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign row_ok    = (7'(row) < 7'(ROWS));
  assign col_ok    = (7'(col) < 7'(COLS));
  assign last_col  = (j == CW'(COLS - 1));
  assign out_free  = !rsp_valid || rsp_ready;
  assign list_full = (n == NW'(cct_pkg::MAX_ITEMS - 1));
  assign cnt_zero  = (cnt_rd == '0);

  // saturating add: room left is the complement of the stored count
  assign room_ext = MW'(~cnt_rd);
  assign amt_ext  = MW'(amount_q);
  assign add_amt  = (amt_ext < room_ext) ? CB'(amt_ext) : ~cnt_rd;

  assign pct_val = (tot_rd == '0) ? '0 : div_stat.quot;
  assign pass    = (pct_val >= min_q);
  assign take    = best_q ? (!have || (pct_val > pend_pct)) : (pass && !have);

  cct_div #(
    .NUM_W (NUMW),
    .DEN_W (TW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (NUMW'(cnt_rd) * NUMW'(cct_pkg::PCT_SCALE)),
    .den   (tot_rd),
    .stat  (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cct_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cct_pkg::ST_CLEAR: begin
        if (clr_addr == '1) state_next = cct_pkg::ST_IDLE;
      end
      cct_pkg::ST_IDLE: begin
        if (accept) begin
          case (cct_pkg::cmd_t'(cmd))
            cct_pkg::CMD_CLEAR: state_next = cct_pkg::ST_CLEAR;
            cct_pkg::CMD_HIT: begin
              if (row_ok && col_ok) state_next = cct_pkg::ST_HIT_WR;
            end
            cct_pkg::CMD_QUERY: begin
              state_next = row_ok ? cct_pkg::ST_Q_RD : cct_pkg::ST_Q_END;
            end
            default: state_next = cct_pkg::ST_IDLE;
          endcase
        end
      end
      cct_pkg::ST_HIT_WR: state_next = cct_pkg::ST_IDLE;
      cct_pkg::ST_Q_RD:   state_next = cct_pkg::ST_Q_CHK;
      cct_pkg::ST_Q_CHK: begin
        if (!cnt_zero) state_next = cct_pkg::ST_Q_DIV;
        else state_next = last_col ? cct_pkg::ST_Q_END : cct_pkg::ST_Q_RD;
      end
      cct_pkg::ST_Q_DIV: begin
        if (div_stat.done) begin
          if (!best_q && pass && have) begin
            state_next = cct_pkg::ST_Q_EMIT;
          end else if (last_col || (!best_q && pass && list_full)) begin
            state_next = cct_pkg::ST_Q_END;
          end else begin
            state_next = cct_pkg::ST_Q_RD;
          end
        end
      end
      cct_pkg::ST_Q_EMIT: begin
        if (out_free) begin
          state_next = (last_col || list_full) ? cct_pkg::ST_Q_END : cct_pkg::ST_Q_RD;
        end
      end
      cct_pkg::ST_Q_END: begin
        if (out_free) state_next = cct_pkg::ST_IDLE;
      end
      default: state_next = cct_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cnt_we    = 1'b0;
    cnt_wa    = {row_q, col_q};
    cnt_wd    = cnt_rd + add_amt;
    tot_we    = 1'b0;
    tot_wa    = row_q;
    tot_wd    = tot_rd + TW'(add_amt);
    cnt_re    = 1'b0;
    cnt_ra    = {row_q, j};
    tot_re    = 1'b0;
    tot_ra    = RW'(row);
    div_start = 1'b0;
    case (state)
      cct_pkg::ST_CLEAR: begin
        cnt_we = 1'b1;
        cnt_wa = clr_addr;
        cnt_wd = '0;
        tot_we = 1'b1;
        tot_wa = clr_addr[AW-1:CW];
        tot_wd = '0;
      end
      cct_pkg::ST_IDLE: begin
        cnt_re = 1'b1;
        cnt_ra = {RW'(row), CW'(col)};
        tot_re = 1'b1;
      end
      cct_pkg::ST_HIT_WR: begin
        cnt_we = 1'b1;
        tot_we = 1'b1;
      end
      cct_pkg::ST_Q_RD:  cnt_re = 1'b1;
      cct_pkg::ST_Q_CHK: div_start = !cnt_zero;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) cnt_rd <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (tot_we) tot_mem[tot_wa] <= tot_wd;
    if (tot_re) tot_rd <= tot_mem[tot_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == cct_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_q    <= RW'(row);
      col_q    <= CW'(col);
      amount_q <= amount;
      min_q    <= min_pct;
      best_q   <= best_only;
    end
  end

  // pending answer flag and count of items taken
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      n    <= '0;
    end else begin
      if (state == cct_pkg::ST_IDLE) begin
        have <= 1'b0;
        n    <= '0;
      end else if ((state == cct_pkg::ST_Q_DIV) && div_stat.done && take) begin
        have <= 1'b1;
        if (!best_q) n <= n + NW'(1);
      end else if ((state == cct_pkg::ST_Q_EMIT) && out_free) begin
        n <= n + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == cct_pkg::ST_IDLE) begin
      j <= CW'(FIRST_COL);
    end else if (state_next == cct_pkg::ST_Q_RD) begin
      j <= j + CW'(1);
    end
    if (((state == cct_pkg::ST_Q_DIV) && div_stat.done && take) ||
        ((state == cct_pkg::ST_Q_EMIT) && out_free)) begin
      pend_col  <= j;
      pend_pct  <= pct_val;
      pend_hits <= cnt_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (((state == cct_pkg::ST_Q_EMIT) || (state == cct_pkg::ST_Q_END)) &&
                 out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == cct_pkg::ST_Q_EMIT) begin
        found     <= 1'b1;
        match_col <= cct_pkg::COL_W'(pend_col);
        pct       <= pend_pct;
        hits      <= cct_pkg::HITS_W'(pend_hits);
        last      <= 1'b0;
      end else if (state == cct_pkg::ST_Q_END) begin
        found     <= have;
        match_col <= have ? cct_pkg::COL_W'(pend_col) : '0;
        pct       <= have ? pend_pct : '0;
        hits      <= have ? cct_pkg::HITS_W'(pend_hits) : '0;
        last      <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/cct_div.sv
`default_nettype none
module cct_div #(
  parameter int NUM_W = cct_pkg::COUNT_BITS_DEF + cct_pkg::PCT_W,
  parameter int DEN_W = cct_pkg::COUNT_BITS_DEF + 5
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [NUM_W-1:0]   num,
  input  wire logic [DEN_W-1:0]   den,
  output cct_pkg::div_stat_t      stat
);

  localparam int XW = DEN_W + cct_pkg::PCT_W;
  localparam int KW = $clog2(cct_pkg::PCT_W);

  logic [XW-1:0]               rem;
  logic [XW-1:0]               dsh;
  logic [cct_pkg::PCT_W-1:0]   quot;
  logic [KW-1:0]               k;
  logic                        running;
  logic                        done;
  logic                        ge;

  // restoring division, one quotient bit per cycle, msb first
  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && (k == KW'(cct_pkg::PCT_W - 1))) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= XW'(num);
      dsh  <= XW'(den) << (cct_pkg::PCT_W - 1);
      quot <= '0;
      k    <= '0;
    end else if (running) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh  <= dsh >> 1;
      quot <= {quot[cct_pkg::PCT_W-2:0], ge};
      k    <= k + KW'(1);
    end
  end

  assign stat.done = done;
  assign stat.quot = quot;

endmodule
`default_nettype wire

### tb/tb_cluster_contingency_table_core.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_cluster_contingency_table_core;

  localparam int ROWS       = cct_pkg::ROWS_DEF;
  localparam int COLS       = cct_pkg::COLS_DEF;
  localparam int FIRST_COL  = cct_pkg::FIRST_COL_DEF;
  localparam int COUNT_BITS = cct_pkg::COUNT_BITS_DEF;
  localparam int HOLD_CYCLES = 500;
  localparam int DRAIN_CYCLES = 400;
  localparam int PHASE_ITEMS = 89;
  localparam int NUM_DIRECTED = 25;
  localparam logic [cct_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [cct_pkg::CMD_W-1:0] cmd;
    logic [cct_pkg::ROW_W-1:0] row;
    logic [cct_pkg::COL_W-1:0] col;
    logic [cct_pkg::AMT_W-1:0] amount;
    logic [cct_pkg::PCT_W-1:0] min_pct;
    logic                      best_only;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  typedef struct packed {
    logic                       found;
    logic [cct_pkg::COL_W-1:0]  match_col;
    logic [cct_pkg::PCT_W-1:0]  pct;
    logic [cct_pkg::HITS_W-1:0] hits;
    logic                       last;
  } answer_t;

  typedef struct packed {
    item_t   req;
    logic    fixed;
    answer_t want;
  } dir_row_t;

  localparam answer_t NO_MATCH = '{1'b0, 5'd0, 7'd0, 16'd0, 1'b1};
  localparam answer_t FULL_COL31 = '{1'b1, 5'd31, 7'd100, 16'hFFFF, 1'b1};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  logic [cct_pkg::CMD_W-1:0] cmd = cct_pkg::CMD_CLEAR;
  logic [cct_pkg::ROW_W-1:0] row = '0;
  logic [cct_pkg::COL_W-1:0] col = '0;
  logic [cct_pkg::AMT_W-1:0] amount = '0;
  logic [cct_pkg::PCT_W-1:0] min_pct = '0;
  logic best_only = 1'b0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic found;
  logic [cct_pkg::COL_W-1:0] match_col;
  logic [cct_pkg::PCT_W-1:0] pct;
  logic [cct_pkg::HITS_W-1:0] hits;
  logic last;

  cluster_contingency_table_core dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .cmd(cmd), .row(row), .col(col), .amount(amount),
    .min_pct(min_pct), .best_only(best_only),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .found(found), .match_col(match_col), .pct(pct), .hits(hits), .last(last)
  );

  always #1 clk = ~clk;

  // shadow copy of the co-occurrence table
  logic [COUNT_BITS-1:0] tally [ROWS][COLS];
  logic [20:0] row_sum [ROWS];
  answer_t pending_answers [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 25;
  int unsigned recv_idle_pct = 66;
  logic hold_trigger = 1'b0;
  logic hold_seen = 1'b0;
  int unsigned hold_left = 0;
  answer_t got_ans, want_ans;
  dir_row_t directed [NUM_DIRECTED];

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic void clear_tally();
    for (int r = 0; r < ROWS; r++) begin
      row_sum[r] = '0;
      for (int c = 0; c < COLS; c++) tally[r][c] = '0;
    end
  endfunction

  function automatic void predict_answers(input item_t it, ref answer_t outq[$]);
    logic [31:0] room, add, p, best_p, cnt, tot;
    int best_c, n;
    answer_t a;
    if (it.cmd == cct_pkg::CMD_CLEAR) begin
      clear_tally();
    end else if (it.cmd == cct_pkg::CMD_HIT) begin
      if (it.row < ROWS && it.col < COLS) begin
        room = 32'(COUNT_MAX) - 32'(tally[it.row][it.col]);
        add = (32'(it.amount) < room) ? 32'(it.amount) : room;
        tally[it.row][it.col] = tally[it.row][it.col] + COUNT_BITS'(add);
        row_sum[it.row] = row_sum[it.row] + 21'(add);
      end
    end else if (it.cmd == cct_pkg::CMD_QUERY) begin
      n = 0;
      best_c = -1;
      best_p = 0;
      if (it.row < ROWS) begin
        tot = 32'(row_sum[it.row]);
        for (int c = FIRST_COL; c < COLS; c++) begin
          cnt = 32'(tally[it.row][c]);
          if (cnt != 0) begin
            p = (tot == 0) ? 32'd0 : (cnt * cct_pkg::PCT_SCALE) / tot;
            if (it.best_only) begin
              if (best_c < 0 || p > best_p) begin
                best_c = c;
                best_p = p;
              end
            end else if (p >= it.min_pct && n < cct_pkg::MAX_ITEMS) begin
              a = '{1'b1, cct_pkg::COL_W'(c), cct_pkg::PCT_W'(p),
                    cct_pkg::HITS_W'(cnt), 1'b0};
              outq.push_back(a);
              n++;
            end
          end
        end
        if (it.best_only && best_c >= 0) begin
          a = '{1'b1, cct_pkg::COL_W'(best_c), cct_pkg::PCT_W'(best_p),
                cct_pkg::HITS_W'(tally[it.row][best_c]), 1'b1};
          outq.push_back(a);
          n = 1;
        end
      end
      if (n == 0) outq.push_back(NO_MATCH);
      else outq[outq.size()-1].last = 1'b1;
    end
  endfunction

  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd <= it.cmd;
    row <= it.row;
    col <= it.col;
    amount <= it.amount;
    min_pct <= it.min_pct;
    best_only <= it.best_only;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic push_item(input item_t it);
    send_item(it);
    predict_answers(it, pending_answers);
  endtask

  function automatic item_t random_fill();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[ITEM_W-1:0];
  endfunction

  function automatic item_t random_item();
    item_t it;
    int unsigned roll, pick;
    it = random_fill();
    roll = $urandom_range(99);
    pick = $urandom_range(9);
    if (pick == 0) it.row = cct_pkg::ROW_W'($urandom_range(63));
    else if (pick < 3) it.row = cct_pkg::ROW_W'($urandom_range(ROWS - 1));
    else it.row = cct_pkg::ROW_W'($urandom_range(3));
    if (roll < 2) begin
      it.cmd = cct_pkg::CMD_CLEAR;
    end else if (roll < 4) begin
      it.cmd = CMD_UNUSED;
    end else if (roll < 66) begin
      it.cmd = cct_pkg::CMD_HIT;
      pick = $urandom_range(9);
      if (pick == 0) it.amount = '1;
      else if (pick == 2) it.amount = '0;
      else if (pick != 1) it.amount = cct_pkg::AMT_W'($urandom_range(300));
    end else begin
      it.cmd = cct_pkg::CMD_QUERY;
      pick = $urandom_range(9);
      if (pick == 0) it.min_pct = cct_pkg::PCT_W'($urandom_range(127, 101));
      else if (pick == 1) it.min_pct = '0;
      else it.min_pct = cct_pkg::PCT_W'($urandom_range(100));
    end
    return it;
  endfunction

  // every column of one row gets counts, then the row is queried
  task automatic fill_row(input int unsigned r);
    item_t it;
    for (int c = 0; c < COLS; c++) begin
      it = random_fill();
      it.cmd = cct_pkg::CMD_HIT;
      it.row = cct_pkg::ROW_W'(r);
      it.col = cct_pkg::COL_W'(c);
      it.amount = cct_pkg::AMT_W'($urandom_range(500, 1));
      push_item(it);
    end
    for (int q = 0; q < 4; q++) begin
      it = random_fill();
      it.cmd = cct_pkg::CMD_QUERY;
      it.row = cct_pkg::ROW_W'(r);
      it.best_only = (q == 3);
      it.min_pct = (q == 0) ? 7'd0 : 7'($urandom_range(5));
      push_item(it);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      got_ans = '{found, match_col, pct, hits, last};
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("result item with none expected: %h", got_ans));
      end else begin
        want_ans = pending_answers.pop_front();
        check_field("found", 32'(got_ans.found), 32'(want_ans.found));
        check_field("match_col", 32'(got_ans.match_col), 32'(want_ans.match_col));
        check_field("pct", 32'(got_ans.pct), 32'(want_ans.pct));
        check_field("hits", 32'(got_ans.hits), 32'(want_ans.hits));
        check_field("last", 32'(got_ans.last), 32'(want_ans.last));
      end
    end
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    answer_t scratch [$];
    clear_tally();
    directed = '{
      '{'{cct_pkg::CMD_QUERY, 6'd0, 5'd0, 16'd0, 7'd0, 1'b1}, 1'b1, NO_MATCH},
      '{'{cct_pkg::CMD_QUERY, 6'd0, 5'd0, 16'd0, 7'd0, 1'b0}, 1'b1, NO_MATCH},
      '{'{cct_pkg::CMD_HIT, 6'd0, 5'd0, 16'd100, 7'd0, 1'b0}, 1'b0, NO_MATCH},
      // column below the first scanned one stays invisible
      '{'{cct_pkg::CMD_QUERY, 6'd0, 5'd0, 16'd0, 7'd0, 1'b1}, 1'b1, NO_MATCH},
      '{'{cct_pkg::CMD_HIT, 6'd0, 5'd1, 16'hFFFF, 7'd0, 1'b0}, 1'b0, NO_MATCH},
      '{'{cct_pkg::CMD_HIT, 6'd0, 5'd1, 16'd1, 7'd0, 1'b0}, 1'b0, NO_MATCH},
      '{'{cct_pkg::CMD_HIT, 6'd0, 5'd31, 16'd0, 7'd0, 1'b0}, 1'b0, NO_MATCH},
      '{'{cct_pkg::CMD_HIT, 6'd0, 5'd31, 16'd1, 7'd0, 1'b0}, 1'b0, NO_MATCH},
      '{'{cct_pkg::CMD_QUERY, 6'd0, 5'd0, 16'd0, 7'd0, 1'b1}, 1'b0, NO_MATCH},
      '{'{cct_pkg::CMD_QUERY, 6'd0, 5'd0, 16'd0, 7'd0, 1'b0}, 1'b0, NO_MATCH},
      '{'{cct_pkg::CMD_QUERY, 6'd0, 5'd0, 16'd0, 7'd127, 1'b0}, 1'b1, NO_MATCH},
      '{'{cct_pkg::CMD_HIT, 6'd63, 5'd5, 16'd5, 7'd0, 1'b0}, 1'b0, NO_MATCH},
      '{'{cct_pkg::CMD_HIT, 6'd32, 5'd31, 16'hFFFF, 7'd0, 1'b0}, 1'b0, NO_MATCH},
      '{'{cct_pkg::CMD_QUERY, 6'd63, 5'd31, 16'hFFFF, 7'd0, 1'b1}, 1'b1, NO_MATCH},
      '{'{cct_pkg::CMD_HIT, 6'd31, 5'd31, 16'hFFFF, 7'd0, 1'b0}, 1'b0, NO_MATCH},
      '{'{cct_pkg::CMD_QUERY, 6'd31, 5'd0, 16'd0, 7'd100, 1'b0}, 1'b1, FULL_COL31},
      '{'{CMD_UNUSED, 6'd63, 5'd31, 16'hFFFF, 7'd127, 1'b1}, 1'b0, NO_MATCH},
      // equal percentages: lowest column wins
      '{'{cct_pkg::CMD_HIT, 6'd2, 5'd3, 16'd10, 7'd0, 1'b0}, 1'b0, NO_MATCH},
      '{'{cct_pkg::CMD_HIT, 6'd2, 5'd7, 16'd10, 7'd0, 1'b0}, 1'b0, NO_MATCH},
      '{'{cct_pkg::CMD_QUERY, 6'd2, 5'd0, 16'd0, 7'd0, 1'b1}, 1'b0, NO_MATCH},
      // best column with a zero percentage
      '{'{cct_pkg::CMD_HIT, 6'd4, 5'd0, 16'hFFFF, 7'd0, 1'b0}, 1'b0, NO_MATCH},
      '{'{cct_pkg::CMD_HIT, 6'd4, 5'd9, 16'd1, 7'd0, 1'b0}, 1'b0, NO_MATCH},
      '{'{cct_pkg::CMD_QUERY, 6'd4, 5'd0, 16'd0, 7'd0, 1'b1}, 1'b0, NO_MATCH},
      '{'{cct_pkg::CMD_CLEAR, 6'd0, 5'd0, 16'd0, 7'd0, 1'b0}, 1'b0, NO_MATCH},
      '{'{cct_pkg::CMD_QUERY, 6'd31, 5'd0, 16'd0, 7'd0, 1'b0}, 1'b1, NO_MATCH}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_item(directed[i].req);
      scratch.delete();
      predict_answers(directed[i].req, scratch);
      if (directed[i].fixed) pending_answers.push_back(directed[i].want);
      else foreach (scratch[k]) pending_answers.push_back(scratch[k]);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 66 : 0;
      recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 25 : 0;
      // long receiver hold while the sender keeps pushing queries
      if (ph == 0) hold_trigger <= ~hold_trigger;
      fill_row($urandom_range(ROWS - 1));
      repeat (PHASE_ITEMS) push_item(random_item());
    end
    req_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
rtl/cct_pkg.sv
rtl/cct_div.sv
rtl/cluster_contingency_table_core.sv
tb/tb_cluster_contingency_table_core.sv
